// ===== sv/qwf_pkg.sv =====
package qwf_pkg;

    localparam logic [4:0] PREFIX_MAX       = 5'd16;
    localparam int         PREFIX_BYTES     = 16;
    localparam logic [6:0] FOLD_ANY         = 7'd72;
    localparam logic [6:0] FOLD_ESC         = 7'd70;
    localparam int         QWF_QUEUE_DEPTH  = 4;
    localparam logic [4:0] PLEN_RESET       = 5'd15;

    localparam logic [1:0] REG_PREFIX_LENGTH = 2'd0;
    localparam logic [1:0] REG_PREFIX_LOW    = 2'd1;
    localparam logic [1:0] REG_PREFIX_HIGH   = 2'd2;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_ESC   = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic [4:0]                  plen;
        logic [8*PREFIX_BYTES-1:0]   prefix;
    } cfg_t;

    typedef struct packed {
        logic       pre;
        logic       fold;
        logic [1:0] kind;
        logic [7:0] data;
    } job_t;

    function automatic logic is_special(input logic [7:0] b);
        return b[7] || (b inside {8'h40, 8'h3C, 8'h3E, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h3B,
                                  8'h3A, 8'h2E, 8'h2C, 8'h5C, 8'h22, 8'h3F, 8'h2F, 8'h3D,
                                  8'h0A, 8'h0D});
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
    endfunction

endpackage

// ===== sv/qwf_cfg.sv =====
module qwf_cfg
    import qwf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [4:0]  plen_reg;
    logic [63:0] low_reg;
    logic [63:0] high_reg;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= PLEN_RESET;
            low_reg  <= '0;
            high_reg <= '0;
        end else if (wr_en) begin
            case (paddr[4:3])
                REG_PREFIX_LENGTH: plen_reg <= pwdata[4:0];
                REG_PREFIX_LOW:    low_reg  <= pwdata;
                REG_PREFIX_HIGH:   high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_PREFIX_LENGTH: prdata = {59'd0, plen_reg};
            REG_PREFIX_LOW:    prdata = low_reg;
            REG_PREFIX_HIGH:   prdata = high_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.plen   = (plen_reg > PREFIX_MAX) ? PREFIX_MAX : plen_reg;
    assign cfg.prefix = {high_reg, low_reg};

endmodule

// ===== sv/qwf_front.sv =====
module qwf_front
    import qwf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    output logic       push_valid,
    input  logic       push_ready,
    output job_t       push_job
);

    logic       open_reg, open_next;
    logic [6:0] len_reg, len_next;
    logic [6:0] plen7;
    logic [6:0] len0;
    logic [6:0] len1;
    logic       esc;
    logic       fold;
    logic       accept;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    always_comb begin
        plen7 = {2'b00, cfg.plen};
        len0  = open_reg ? len_reg : plen7;
        esc   = is_special(s_tdata);
        fold  = !s_tuser && ((len0 >= FOLD_ANY) || (esc && (len0 >= FOLD_ESC)));
        len1  = fold ? plen7 : len0;

        push_job.pre  = !open_reg;
        push_job.fold = fold;
        push_job.data = s_tdata;
        if (s_tuser) begin
            push_job.kind = KIND_CLOSE;
        end else if (esc) begin
            push_job.kind = KIND_ESC;
        end else begin
            push_job.kind = KIND_PLAIN;
            if (s_tdata == CH_SPACE) begin
                push_job.data = CH_UNDER;
            end
        end

        open_next = open_reg;
        len_next  = len_reg;
        if (accept) begin
            if (s_tuser) begin
                open_next = 1'b0;
                len_next  = '0;
            end else begin
                open_next = 1'b1;
                len_next  = len1 + (esc ? 7'd3 : 7'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            len_reg  <= '0;
        end else begin
            open_reg <= open_next;
            len_reg  <= len_next;
        end
    end

endmodule

// ===== sv/qwf_queue.sv =====
module qwf_queue
    import qwf_pkg::*;
#(
    parameter int DEPTH = QWF_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push, pop;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign out_job   = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = push ? ((wr_reg == LAST_PTR) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? ((rd_reg == LAST_PTR) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= in_job;
        end
    end

endmodule

// ===== sv/qwf_back.sv =====
module qwf_back
    import qwf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job_in,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_FOLD   = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    logic       act_reg, act_next;
    job_t       job_reg, job_next;
    logic [1:0] ph_reg, ph_next;
    logic [3:0] idx_reg, idx_next;
    logic       vld_reg, vld_next;
    logic [7:0] dat_reg, dat_next;
    logic       lst_reg, lst_next;

    logic [7:0] cur_byte;
    logic       done_now;
    logic       adv, fire, load;
    logic [4:0] plen_m1;
    logic [1:0] start_ph;

    assign m_tvalid  = vld_reg;
    assign m_tdata   = dat_reg;
    assign m_tlast   = lst_reg;
    assign job_ready = load;

    always_comb begin
        cur_byte = job_reg.data;
        done_now = 1'b0;
        case (ph_reg)
            PH_PREFIX: cur_byte = cfg.prefix[{idx_reg, 3'b000} +: 8];
            PH_FOLD: begin
                case (idx_reg[1:0])
                    2'd0:    cur_byte = CH_QMARK;
                    2'd1:    cur_byte = CH_EQ;
                    2'd2:    cur_byte = CH_LF;
                    default: cur_byte = CH_SPACE;
                endcase
            end
            PH_BODY: begin
                case (job_reg.kind)
                    KIND_CLOSE: begin
                        cur_byte = (idx_reg == 4'd0) ? CH_QMARK : CH_EQ;
                        done_now = (idx_reg == 4'd1);
                    end
                    KIND_ESC: begin
                        if (idx_reg == 4'd0) begin
                            cur_byte = CH_EQ;
                        end else if (idx_reg == 4'd1) begin
                            cur_byte = hex_char(job_reg.data[7:4]);
                        end else begin
                            cur_byte = hex_char(job_reg.data[3:0]);
                        end
                        done_now = (idx_reg == 4'd2);
                    end
                    default: begin
                        cur_byte = job_reg.data;
                        done_now = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        adv     = !vld_reg || m_tready;
        fire    = act_reg && adv;
        load    = job_valid && (!act_reg || (fire && done_now));
        plen_m1 = cfg.plen - 5'd1;

        if (job_in.pre && (cfg.plen != '0)) begin
            start_ph = PH_PREFIX;
        end else if (job_in.fold) begin
            start_ph = PH_FOLD;
        end else begin
            start_ph = PH_BODY;
        end

        act_next = act_reg;
        job_next = job_reg;
        ph_next  = ph_reg;
        idx_next = idx_reg;
        if (load) begin
            act_next = 1'b1;
            job_next = job_in;
            ph_next  = start_ph;
            idx_next = '0;
        end else if (fire) begin
            if (done_now) begin
                act_next = 1'b0;
            end else begin
                case (ph_reg)
                    PH_PREFIX: begin
                        if ({1'b0, idx_reg} == plen_m1) begin
                            ph_next  = PH_BODY;
                            idx_next = '0;
                        end else begin
                            idx_next = idx_reg + 4'd1;
                        end
                    end
                    PH_FOLD: begin
                        if (idx_reg == 4'd3) begin
                            ph_next  = (cfg.plen != '0) ? PH_PREFIX : PH_BODY;
                            idx_next = '0;
                        end else begin
                            idx_next = idx_reg + 4'd1;
                        end
                    end
                    default: idx_next = idx_reg + 4'd1;
                endcase
            end
        end

        vld_next = vld_reg;
        dat_next = dat_reg;
        lst_next = lst_reg;
        if (fire) begin
            vld_next = 1'b1;
            dat_next = cur_byte;
            lst_next = done_now;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            ph_reg  <= PH_BODY;
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            act_reg <= act_next;
            ph_reg  <= ph_next;
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        dat_reg <= dat_next;
        lst_reg <= lst_next;
    end

endmodule

// ===== sv/q_encoded_word_folder.sv =====
// Channel   Dir  Beat contents
// s_        in   tdata[7:0] data_byte, tuser cmd (1 = close word)
// m_        out  tdata[7:0] out_byte, tlast last_of_run
// apb       in   prefix_length @0x00, prefix_low @0x08, prefix_high @0x10
//
// One output beat per cycle while m_tready is high and a job is queued; an
// input beat yields 1 byte for a plain byte, 3 for an escape, 2 for a close,
// plus the prefix length for a new word and 4 plus the prefix length for a fold.
// The front takes a beat each cycle while the job queue has room.
// Reset clears the word state, the queue and the output valid flag.
// An m_ stall holds the output register; the queue absorbs input meanwhile.
module q_encoded_word_folder
    import qwf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QWF_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    job_t push_job, pop_job;
    logic push_valid, push_ready, pop_valid, pop_ready;

    qwf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qwf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    qwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_job   (pop_job)
    );

    qwf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_in    (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== sv/qwf_checker.sv =====
module qwf_checker
    import qwf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [63:0] pwdata,
    input logic [63:0] prdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_reset_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite
        && (paddr[4:3] == REG_PREFIX_LOW || paddr[4:3] == REG_PREFIX_HIGH)
        |=> (paddr[4:3] != $past(paddr[4:3])) || (prdata == $past(pwdata)))
        else $error("prefix register readback mismatch");

endmodule

bind q_encoded_word_folder qwf_checker u_chk (.*);
